[rtl/core/xbm_pkg.sv]
// shared types and constants for the xbm hex body decoder
// request, result and command structs, character codes, status codes
// no dependencies
package xbm_pkg;

   // fixed field widths
   localparam int CFG_BITS     = 16;
   localparam int OUT_BITS     = 16;
   localparam int CSR_IDX_BITS = 1;
   localparam int QUEUE_DEPTH  = 4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;
   localparam logic [CFG_BITS-1:0]     CFG_RESET_DIM    = 16'd8;

   // character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_X_LO   = 8'h78;
   localparam logic [7:0] CH_X_UP   = 8'h58;
   localparam logic [7:0] CH_DIG0   = 8'h30;
   localparam logic [7:0] CH_DIG9   = 8'h39;
   localparam logic [7:0] CH_A_LO   = 8'h61;
   localparam logic [7:0] CH_F_LO   = 8'h66;
   localparam logic [7:0] CH_A_UP   = 8'h41;
   localparam logic [7:0] CH_F_UP   = 8'h46;

   // result kinds and status codes
   localparam logic       KIND_PIXEL  = 1'b0;
   localparam logic       KIND_STATUS = 1'b1;
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_CORRUPT  = 2'd1;
   localparam logic [1:0] ST_TRUNC    = 2'd2;

   localparam logic [3:0] PIX_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic                result_kind;
      logic [OUT_BITS-1:0] pixel_col;
      logic [OUT_BITS-1:0] pixel_row;
      logic                pixel_set;
      logic [1:0]          status_code;
      logic                run_last;
   } rsp_type;

   // one unit of work for the back end: pixels of a byte and/or a status
   typedef struct packed {
      logic [OUT_BITS-1:0] col_base;
      logic [OUT_BITS-1:0] row;
      logic [7:0]          data;
      logic [3:0]          npix;
      logic                status_valid;
      logic [1:0]          status_code;
   } cmd_type;

endpackage

[rtl/core/xbm_hex_body_decoder_top.sv]
// channel  | handshake             | payload
// req      | req_valid/req_ready   | req_data  (char_code, end_of_text)
// rsp      | rsp_valid/rsp_ready   | rsp_data  (kind, col, row, set, status, last)
// csr      | csr_valid/csr_ready   | csr_index, csr_wdata (width, height)
//
// the front end takes one character per cycle while the command queue has room
// the back end sends one result per cycle unless stalled: a byte with n visible
// pixels gives n results, plus one for a status; the four-entry queue absorbs bursts
// the output stage is a register, so requests keep flowing while a result waits
// synchronous reset returns the scanner to waiting for a brace, width and height to 8
// top level: front end, command queue, back end; depends on xbm_pkg
module xbm_hex_body_decoder_top #(
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  xbm_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output xbm_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [xbm_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [xbm_pkg::CFG_BITS-1:0]      csr_wdata
);
   import xbm_pkg::*;

   logic    cmd_push, cmd_full, cmd_pop, cmd_valid;
   cmd_type cmd_in, cmd_head;

   xbm_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in),
      .cmd_full  (cmd_full)
   );

   xbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_in),
      .full       (cmd_full),
      .pop        (cmd_pop),
      .head_valid (cmd_valid),
      .head_data  (cmd_head)
   );

   xbm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/xbm_front.sv]
// front end: configuration registers, character scanner, hex byte assembly,
// column and row tracking; emits commands to the queue
// depends on xbm_pkg
module xbm_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  xbm_pkg::req_type                  req_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [xbm_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [xbm_pkg::CFG_BITS-1:0]      csr_wdata,
   output logic                              cmd_push,
   output xbm_pkg::cmd_type                  cmd_data,
   input  logic                              cmd_full
);
   import xbm_pkg::*;

   typedef enum logic [3:0] {
      PH_WAIT   = 4'b0001,
      PH_SCAN   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   // hex digit decode: {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] v;
      begin
         v = 8'd0;
         if (c >= CH_DIG0 && c <= CH_DIG9) begin
            v = c - CH_DIG0;
            hex_decode = {1'b1, v[3:0]};
         end else if (c >= CH_A_LO && c <= CH_F_LO) begin
            v = c - CH_A_LO + 8'd10;
            hex_decode = {1'b1, v[3:0]};
         end else if (c >= CH_A_UP && c <= CH_F_UP) begin
            v = c - CH_A_UP + 8'd10;
            hex_decode = {1'b1, v[3:0]};
         end else begin
            hex_decode = {1'b0, v[3:0]};
         end
      end
   endfunction

   logic [CFG_BITS-1:0]   width_ff, width_in;
   logic [CFG_BITS-1:0]   height_ff, height_in;
   phase_type             phase_ff, phase_in;
   logic                  zero_ff, zero_in;
   logic                  dcnt_ff, dcnt_in;
   logic [7:0]            accum_ff, accum_in;
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;

   logic [COORD_BITS+CFG_BITS-1:0] width_ext, height_ext;
   logic [COORD_BITS-1:0]          img_w, img_h;
   logic [COORD_BITS:0]            col_plus8;
   logic [COORD_BITS-1:0]          col_left, row_next;
   logic [3:0]                     fin_npix;
   logic                           fin_wrap, fin_done;
   logic [OUT_BITS+COORD_BITS-1:0] col_out_ext, row_out_ext;

   logic       accept, end_flag;
   logic [4:0] hex;
   logic [7:0] accum_shift;
   phase_type  phase_mid, phase_nx;
   logic       zero_mid, zero_nx, dcnt_mid, dcnt_nx;
   logic [7:0] accum_mid, accum_nx, fin_byte, fin_byte_char;
   logic       fin_char, fin_any, st_valid;
   logic [1:0] st_code;
   logic [COORD_BITS-1:0] col_nx, row_nx;

   // configuration port
   assign csr_ready = 1'b1;
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // dimensions at coordinate width
   assign width_ext  = {{COORD_BITS{1'b0}}, width_ff};
   assign height_ext = {{COORD_BITS{1'b0}}, height_ff};
   assign img_w      = width_ext[COORD_BITS-1:0];
   assign img_h      = height_ext[COORD_BITS-1:0];

   // byte completion arithmetic from the current position
   assign col_plus8 = {1'b0, col_ff} + (COORD_BITS+1)'(8);
   assign col_left  = img_w - col_ff;
   assign row_next  = row_ff + COORD_BITS'(1);
   assign fin_wrap  = col_plus8 >= {1'b0, img_w};
   assign fin_done  = fin_wrap && (row_next >= img_h);
   always_comb begin
      if (img_w <= col_ff)
         fin_npix = 4'd0;
      else if (col_left >= COORD_BITS'(8))
         fin_npix = PIX_PER_BYTE;
      else
         fin_npix = col_left[3:0];
   end

   assign accept    = req_valid && !cmd_full;
   assign req_ready = !cmd_full;
   assign end_flag  = (req_data.char_code == CH_NUL) || req_data.end_of_text;
   assign hex       = hex_decode(req_data.char_code);
   assign accum_shift = {accum_ff[3:0], hex[3:0]};

   // character part of the step
   always_comb begin
      phase_mid     = phase_ff;
      zero_mid      = zero_ff;
      dcnt_mid      = dcnt_ff;
      accum_mid     = accum_ff;
      fin_char      = 1'b0;
      fin_byte_char = accum_ff;
      st_valid      = 1'b0;
      st_code       = ST_OK;
      if (req_data.char_code != CH_NUL) begin
         case (phase_ff)
            PH_WAIT: begin
               if (req_data.char_code == CH_LBRACE) begin
                  if (img_w == '0 || img_h == '0) begin
                     st_valid  = 1'b1;
                     st_code   = ST_OK;
                     phase_mid = PH_DONE;
                  end else begin
                     phase_mid = PH_SCAN;
                     zero_mid  = 1'b0;
                  end
               end
            end
            PH_SCAN: begin
               if (zero_ff && (req_data.char_code == CH_X_LO ||
                               req_data.char_code == CH_X_UP)) begin
                  phase_mid = PH_DIGITS;
                  dcnt_mid  = 1'b0;
                  accum_mid = 8'd0;
                  zero_mid  = 1'b0;
               end else begin
                  zero_mid = (req_data.char_code == CH_DIG0);
               end
            end
            PH_DIGITS: begin
               if (hex[4]) begin
                  if (dcnt_ff) begin
                     phase_mid     = PH_SCAN;
                     zero_mid      = 1'b0;
                     dcnt_mid      = 1'b0;
                     fin_char      = 1'b1;
                     fin_byte_char = accum_shift;
                  end else begin
                     dcnt_mid  = 1'b1;
                     accum_mid = accum_shift;
                  end
               end else if (!dcnt_ff) begin
                  st_valid  = 1'b1;
                  st_code   = ST_TRUNC;
                  phase_mid = PH_DONE;
               end else begin
                  // the closing character is not a digit, scanning restarts clear
                  phase_mid     = PH_SCAN;
                  zero_mid      = 1'b0;
                  dcnt_mid      = 1'b0;
                  fin_char      = 1'b1;
                  fin_byte_char = accum_ff;
               end
            end
            PH_DONE: ;
            default: ;
         endcase
      end

      // end of text, byte completion and run clear
      phase_nx = phase_mid;
      zero_nx  = zero_mid;
      dcnt_nx  = dcnt_mid;
      accum_nx = accum_mid;
      col_nx   = col_ff;
      row_nx   = row_ff;
      fin_any  = fin_char;
      fin_byte = fin_byte_char;
      if (end_flag) begin
         case (phase_mid)
            PH_WAIT: begin
               st_valid = 1'b1;
               st_code  = ST_CORRUPT;
            end
            PH_SCAN: begin
               st_valid = 1'b1;
               st_code  = ST_TRUNC;
            end
            PH_DIGITS: begin
               if (!dcnt_mid) begin
                  st_valid = 1'b1;
                  st_code  = ST_TRUNC;
               end else begin
                  fin_any  = 1'b1;
                  fin_byte = accum_mid;
                  if (!fin_done) begin
                     st_valid = 1'b1;
                     st_code  = ST_TRUNC;
                  end
               end
            end
            PH_DONE: ;
            default: ;
         endcase
      end
      if (fin_any) begin
         if (fin_wrap) begin
            col_nx = '0;
            row_nx = row_next;
            if (fin_done) begin
               st_valid = 1'b1;
               st_code  = ST_OK;
               phase_nx = PH_DONE;
            end
         end else begin
            col_nx = col_plus8[COORD_BITS-1:0];
         end
      end
      if (end_flag) begin
         phase_nx = PH_WAIT;
         zero_nx  = 1'b0;
         dcnt_nx  = 1'b0;
         accum_nx = 8'd0;
         col_nx   = '0;
         row_nx   = '0;
      end
   end

   // state update on accepted request
   assign phase_in = accept ? phase_nx : phase_ff;
   assign zero_in  = accept ? zero_nx  : zero_ff;
   assign dcnt_in  = accept ? dcnt_nx  : dcnt_ff;
   assign accum_in = accept ? accum_nx : accum_ff;
   assign col_in   = accept ? col_nx   : col_ff;
   assign row_in   = accept ? row_nx   : row_ff;

   // command toward the back end
   assign col_out_ext = {{OUT_BITS{1'b0}}, col_ff};
   assign row_out_ext = {{OUT_BITS{1'b0}}, row_ff};
   always_comb begin
      cmd_data.col_base     = col_out_ext[OUT_BITS-1:0];
      cmd_data.row          = row_out_ext[OUT_BITS-1:0];
      cmd_data.data         = fin_byte;
      cmd_data.npix         = fin_any ? fin_npix : 4'd0;
      cmd_data.status_valid = st_valid;
      cmd_data.status_code  = st_code;
   end
   assign cmd_push = accept && ((fin_any && fin_npix != 4'd0) || st_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET_DIM;
         height_ff <= CFG_RESET_DIM;
         phase_ff  <= PH_WAIT;
         zero_ff   <= 1'b0;
         dcnt_ff   <= 1'b0;
         accum_ff  <= 8'd0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         phase_ff  <= phase_in;
         zero_ff   <= zero_in;
         dcnt_ff   <= dcnt_in;
         accum_ff  <= accum_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

[rtl/core/xbm_queue.sv]
// command queue between front and back end
// small register fifo of cmd_type entries
// depends on xbm_pkg
module xbm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xbm_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output xbm_pkg::cmd_type head_data
);
   import xbm_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/xbm_back.sv]
// back end: expands a command into pixel results and, if it carries one, a status result
// one result per cycle, while the output slot is free, into a registered output stage
// depends on xbm_pkg
module xbm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  xbm_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output xbm_pkg::rsp_type rsp_data
);
   import xbm_pkg::*;

   logic [3:0] bit_ff, bit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       slot_free, issue, is_pix, last_pix;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign issue     = cmd_valid && slot_free;
   assign is_pix    = bit_ff < cmd_data.npix;
   assign last_pix  = (bit_ff + 4'd1) == cmd_data.npix;

   // next result from the head command
   always_comb begin
      rsp_in = rsp_ff;
      if (is_pix) begin
         rsp_in.result_kind = KIND_PIXEL;
         rsp_in.pixel_col   = cmd_data.col_base + OUT_BITS'(bit_ff);
         rsp_in.pixel_row   = cmd_data.row;
         rsp_in.pixel_set   = cmd_data.data[bit_ff[2:0]];
         rsp_in.status_code = ST_OK;
         rsp_in.run_last    = last_pix && !cmd_data.status_valid;
      end else begin
         rsp_in.result_kind = KIND_STATUS;
         rsp_in.pixel_col   = '0;
         rsp_in.pixel_row   = '0;
         rsp_in.pixel_set   = 1'b0;
         rsp_in.status_code = cmd_data.status_code;
         rsp_in.run_last    = 1'b1;
      end
   end

   // pop when the last result of the command goes out
   assign cmd_pop = issue && (is_pix ? (last_pix && !cmd_data.status_valid) : 1'b1);

   always_comb begin
      bit_in = bit_ff;
      if (cmd_pop)
         bit_in = 4'd0;
      else if (issue)
         bit_in = bit_ff + 4'd1;
      rsp_valid_in = issue ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (issue)
         rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[bench/xbm_decode_checker.sv]
`timescale 1ns / 100ps
// checker for the xbm hex body decoder: watches the request, result and csr channels
// keeps its own decoder state, predicts pixel and status results, compares in order
// depends on xbm_pkg
module xbm_decode_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  xbm_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  xbm_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [xbm_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [xbm_pkg::CFG_BITS-1:0]     csr_wdata,
   output int               outstanding,
   output int               mismatches
);
   import xbm_pkg::*;

   typedef enum logic [3:0] {
      AWAIT_BRACE = 4'b0001,
      SCAN_TEXT   = 4'b0010,
      READ_DIGITS = 4'b0100,
      IMAGE_DONE  = 4'b1000
   } scan_phase_type;

   localparam int COORD_MASK = (1 << OUT_BITS) - 1;

   // decoder copy
   logic [CFG_BITS-1:0] width_cfg;
   logic [CFG_BITS-1:0] height_cfg;
   scan_phase_type      phase;
   logic                after_zero;
   logic [1:0]          digits;
   logic [7:0]          byte_acc;
   int                  col_base;
   int                  row_idx;
   int                  fail_count = 0;

   rsp_type decoded_q[$];
   rsp_type burst[$];

   // {valid, value} of a hex digit character
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CH_DIG0 && c <= CH_DIG9) begin
         d = c - CH_DIG0;
         return {1'b1, d[3:0]};
      end
      if (c >= CH_A_LO && c <= CH_F_LO) begin
         d = c - CH_A_LO + 8'd10;
         return {1'b1, d[3:0]};
      end
      if (c >= CH_A_UP && c <= CH_F_UP) begin
         d = c - CH_A_UP + 8'd10;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   task automatic add_result(input logic kind, input int col, input int row,
                             input logic set, input logic [1:0] status);
      rsp_type r;
      r.result_kind = kind;
      r.pixel_col   = col[OUT_BITS-1:0];
      r.pixel_row   = row[OUT_BITS-1:0];
      r.pixel_set   = set;
      r.status_code = status;
      r.run_last    = 1'b0;
      burst.push_back(r);
   endtask

   task automatic clear_run();
      phase      = AWAIT_BRACE;
      after_zero = 1'b0;
      digits     = 2'd0;
      byte_acc   = 8'd0;
      col_base   = 0;
      row_idx    = 0;
   endtask

   // pixels of a completed byte, row advance, ok once the last row is filled
   task automatic finish_byte(output bit image_done);
      int b;
      image_done = 1'b0;
      for (b = 0; b < int'(PIX_PER_BYTE) && col_base + b < int'(width_cfg); b++)
         add_result(KIND_PIXEL, col_base + b, row_idx, byte_acc[b], ST_OK);
      if (col_base + int'(PIX_PER_BYTE) >= int'(width_cfg)) begin
         col_base = 0;
         row_idx  = (row_idx + 1) & COORD_MASK;
         if (row_idx >= int'(height_cfg)) begin
            add_result(KIND_STATUS, 0, 0, 1'b0, ST_OK);
            phase      = IMAGE_DONE;
            image_done = 1'b1;
         end
      end else begin
         col_base = (col_base + int'(PIX_PER_BYTE)) & COORD_MASK;
      end
   endtask

   // one character in, its results appended to the expected queue
   task automatic decode_char(input req_type r);
      logic [4:0] hv;
      bit         at_end;
      bit         done;
      burst.delete();
      at_end = (r.char_code == CH_NUL) || r.end_of_text;
      if (r.char_code != CH_NUL) begin
         case (phase)
            AWAIT_BRACE: begin
               if (r.char_code == CH_LBRACE) begin
                  if (width_cfg == '0 || height_cfg == '0) begin
                     add_result(KIND_STATUS, 0, 0, 1'b0, ST_OK);
                     phase = IMAGE_DONE;
                  end else begin
                     phase      = SCAN_TEXT;
                     after_zero = 1'b0;
                  end
               end
            end
            SCAN_TEXT: begin
               if (after_zero && (r.char_code == CH_X_LO || r.char_code == CH_X_UP)) begin
                  phase      = READ_DIGITS;
                  digits     = 2'd0;
                  byte_acc   = 8'd0;
                  after_zero = 1'b0;
               end else begin
                  after_zero = (r.char_code == CH_DIG0);
               end
            end
            READ_DIGITS: begin
               hv = hex_digit(r.char_code);
               if (hv[4]) begin
                  byte_acc = {byte_acc[3:0], hv[3:0]};
                  digits   = digits + 2'd1;
                  if (digits >= 2'd2) begin
                     phase      = SCAN_TEXT;
                     after_zero = 1'b0;
                     digits     = 2'd0;
                     finish_byte(done);
                  end
               end else if (digits == 2'd0) begin
                  // 0x with no digit
                  add_result(KIND_STATUS, 0, 0, 1'b0, ST_TRUNC);
                  phase = IMAGE_DONE;
               end else begin
                  // one digit, byte closed by a non-hex character
                  phase      = SCAN_TEXT;
                  after_zero = 1'b0;
                  digits     = 2'd0;
                  finish_byte(done);
               end
            end
            default: ;
         endcase
      end
      // end of text closes the run and clears the scanner
      if (at_end) begin
         case (phase)
            AWAIT_BRACE: add_result(KIND_STATUS, 0, 0, 1'b0, ST_CORRUPT);
            SCAN_TEXT:   add_result(KIND_STATUS, 0, 0, 1'b0, ST_TRUNC);
            READ_DIGITS: begin
               if (digits == 2'd0) begin
                  add_result(KIND_STATUS, 0, 0, 1'b0, ST_TRUNC);
               end else begin
                  finish_byte(done);
                  if (!done)
                     add_result(KIND_STATUS, 0, 0, 1'b0, ST_TRUNC);
               end
            end
            default: ;
         endcase
         clear_run();
      end
      if (burst.size() > 0)
         burst[burst.size()-1].run_last = 1'b1;
      foreach (burst[i])
         decoded_q.push_back(burst[i]);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // watch all three channels at each edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         width_cfg  = CFG_RESET_DIM;
         height_cfg = CFG_RESET_DIM;
         clear_run();
         decoded_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH)
               width_cfg = csr_wdata;
            else if (csr_index == CSR_IMAGE_HEIGHT)
               height_cfg = csr_wdata;
         end
         if (req_valid && req_ready)
            decode_char(req_data);
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected result: kind %0d col %0d row %0d status %0d",
                      rsp_data.result_kind, rsp_data.pixel_col, rsp_data.pixel_row,
                      rsp_data.status_code);
               fail_count++;
            end else begin
               want = decoded_q.pop_front();
               check_field("result_kind", want.result_kind, rsp_data.result_kind);
               check_field("pixel_col", want.pixel_col, rsp_data.pixel_col);
               check_field("pixel_row", want.pixel_row, rsp_data.pixel_row);
               check_field("pixel_set", want.pixel_set, rsp_data.pixel_set);
               check_field("status_code", want.status_code, rsp_data.status_code);
               check_field("run_last", want.run_last, rsp_data.run_last);
            end
         end
      end
      outstanding <= decoded_q.size();
      mismatches  <= fail_count;
   end

endmodule

[bench/xbm_hex_body_decoder_top_test.sv]
`timescale 1ns / 100ps
// testbench top for the xbm hex body decoder: clock, reset, text stimulus, verdict
// directed texts for each end case, then random xbm bodies under random dimensions
// depends on xbm_pkg, xbm_hex_body_decoder_top and xbm_decode_checker
module xbm_hex_body_decoder_top_test;
   import xbm_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int TOTAL_CHARS   = 375;
   localparam int HOLD_CYCLES   = 150;

   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CFG_BITS-1:0]     csr_wdata = '0;

   int outstanding;
   int mismatches;
   int body_chars    = 0;
   int quiet_cycles  = 0;
   int results_taken = 0;
   int hold_left     = 0;
   bit pressure_done = 1'b0;
   bit steady        = 1'b0;
   int cur_width     = int'(CFG_RESET_DIM);
   int cur_height    = int'(CFG_RESET_DIM);

   xbm_hex_body_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   xbm_decode_checker decode_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls, one long hold while requests keep coming
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         results_taken++;
      if (!pressure_done && results_taken >= 120 && req_valid) begin
         hold_left     = HOLD_CYCLES;
         pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 32);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // one character request, with random idle cycles ahead of it
   task automatic send_char(input logic [7:0] c, input logic eot, input bit live);
      while (!steady && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_data.char_code    <= c;
      req_data.end_of_text  <= eot;
      do @(posedge clock); while (!req_ready);
      if (live)
         body_chars++;
   endtask

   task automatic send_text(input string s, input logic eot);
      int i;
      for (i = 0; i < s.len(); i++)
         send_char(s[i], eot && (i == s.len() - 1), 1'b1);
   endtask

   // drain the block, then write both dimensions
   task automatic set_dims(input int w, input int h);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w[CFG_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h[CFG_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_width  = w;
      cur_height = h;
   endtask

   function automatic logic [7:0] hex_char(input int v);
      if (v < 10)
         return CH_DIG0 + 8'(v);
      if ($urandom_range(1) == 0)
         return CH_A_LO + 8'(v - 10);
      return CH_A_UP + 8'(v - 10);
   endfunction

   // one xbm body: junk, brace, bytes with random separators, then an end; sometimes no brace
   task automatic random_body();
      string      seps;
      int         bytes_needed;
      int         nbytes;
      int         b;
      int         k;
      logic [7:0] c;
      seps = " ,\n";
      repeat ($urandom_range(0, 3))
         send_char(8'($urandom_range(1, 255)), 1'b0, 1'b0);
      // text with no brace at all
      if ($urandom_range(9) == 0) begin
         c = 8'($urandom_range(1, 255));
         if (c == CH_LBRACE)
            c = CH_X_UP;
         send_char(c, 1'b1, 1'b1);
         return;
      end
      if (cur_width == 0 || cur_height == 0)
         bytes_needed = 0;
      else
         bytes_needed = ((cur_width + 7) / 8) * cur_height;
      nbytes = (bytes_needed > 16) ? 16 : bytes_needed;
      if ($urandom_range(5) == 0)
         nbytes = $urandom_range(0, nbytes);
      send_char(CH_LBRACE, 1'b0, 1'b1);
      for (b = 0; b < nbytes; b++) begin
         send_char(seps[$urandom_range(2)], 1'b0, 1'b1);
         if ($urandom_range(19) == 0)
            send_char(8'($urandom_range(1, 255)), 1'b0, 1'b1);
         send_char(CH_DIG0, 1'b0, 1'b1);
         send_char($urandom_range(1) ? CH_X_LO : CH_X_UP, 1'b0, 1'b1);
         // sometimes no digit, sometimes one
         case ($urandom_range(24))
            0:       k = 0;
            1, 2, 3: k = 1;
            default: k = 2;
         endcase
         repeat (k)
            send_char(hex_char($urandom_range(15)), 1'b0, 1'b1);
      end
      case ($urandom_range(2))
         0:       send_text("};", 1'b1);
         1:       send_char(CH_NUL, 1'(($urandom_range(1))), 1'b1);
         default: send_char(8'($urandom_range(1, 255)), 1'b1, 1'b1);
      endcase
   endtask

   // stimulus and verdict
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // no brace: corrupt, by end flag and by zero character
      send_text("A", 1'b1);
      send_char(CH_NUL, 1'b0, 1'b1);

      // two rows of three, one byte closed by a single digit
      set_dims(3, 2);
      send_text("{0xfF,0Xa,;", 1'b1);
      // 0x with no digit, and end right after the brace
      send_text("{0xg", 1'b1);
      send_text("{", 1'b1);

      // empty image gives ok at the brace
      set_dims(0, 5);
      send_text("{", 1'b0);
      send_char(CH_NUL, 1'b0, 1'b1);

      // largest dimensions, text ends inside a one-digit byte
      set_dims(65535, 65535);
      send_text("{0x8", 1'b1);

      // random bodies under changing dimensions
      while (body_chars < TOTAL_CHARS) begin
         if ($urandom_range(1) == 0) begin
            case ($urandom_range(7))
               0:       set_dims(1, 1);
               1:       set_dims(65535, 1);
               2:       set_dims($urandom_range(1, 24), 0);
               3:       set_dims(8, $urandom_range(1, 4));
               default: set_dims($urandom_range(1, 24), $urandom_range(1, 3));
            endcase
         end
         steady <= (body_chars >= 150 && body_chars < 260);
         random_body();
      end

      req_valid <= 1'b0;
      steady    <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/xbm_pkg.sv
rtl/core/xbm_front.sv
rtl/core/xbm_queue.sv
rtl/core/xbm_back.sv
rtl/core/xbm_hex_body_decoder_top.sv
bench/xbm_decode_checker.sv
bench/xbm_hex_body_decoder_top_test.sv
